// ===== rtl/mgoc_pkg.sv =====
// Package: shared constants and types of the median-gated outlier check.
`default_nettype none
package mgoc_pkg;

  localparam int unsigned DEPTH  = 8;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned BAL_W  = $clog2(DEPTH) + 1;
  localparam int unsigned ZC_W   = $clog2(DEPTH + 1);
  localparam int unsigned CFG_W  = 2;
  localparam int unsigned DIFF_W = 31;

  localparam logic [CFG_W-1:0] CFG_MAX_VALID      = 2'd0;
  localparam logic [CFG_W-1:0] CFG_MIN_VALID      = 2'd1;
  localparam logic [CFG_W-1:0] CFG_MAX_DIFFERENCE = 2'd2;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
  } ring_req_t;

endpackage
`default_nettype wire

// ===== rtl/median_gated_outlier_check.sv =====
// Top level: sliding-window median outlier check over a ring of samples.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o, sample_i) carries one signed
//   Q16.16 sample per transaction. Output channel (out_valid_o / out_ready_i)
//   carries valid_res_o, median_o and filled_o, exactly one transaction per
//   input transaction, in order.
//   Each sample is written into a DEPTH-entry ring memory. An in-range sample
//   triggers a rank pass: for every slot the pivot is read, then all DEPTH
//   slots are streamed past it through the single read port, one per cycle.
//   The block takes no new sample during that pass, and a new sample is
//   taken in the cycle after the result is loaded. An out-of-range sample
//   skips the pass and goes straight to the check state that loads its result.
//   A result sits in an output register; if the receiver stalls, it holds
//   there and the block waits before loading the next one. The next sample
//   may be accepted while a result still waits.
//   Reset clears the ring (through per-entry valid bits, no clearing pass),
//   the write slot, the filled flag and the stored median, and restores the
//   configuration registers. Write configuration only while idle.
// ----------------------------------------------------------------------------
`default_nettype none
module median_gated_outlier_check import mgoc_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  // configuration write port
  input  wire logic                     cfg_we_i,
  input  wire logic        [CFG_W-1:0]  cfg_idx_i,
  input  wire logic        [DATA_W-1:0] cfg_data_i,
  // input channel
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic signed [DATA_W-1:0] sample_i,
  // output channel
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic                          valid_res_o,
  output logic signed      [DATA_W-1:0] median_o,
  output logic                          filled_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PIV,
    S_CMP,
    S_DRAIN,
    S_FIN,
    S_CHK
  } state_e;

  // Configuration registers.
  logic signed [DATA_W-1:0] max_valid_q;
  logic signed [DATA_W-1:0] min_valid_q;
  logic        [DIFF_W-1:0] max_diff_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_valid_q <= {1'b0, {(DATA_W-1){1'b1}}};
      min_valid_q <= {1'b1, {(DATA_W-1){1'b0}}};
      max_diff_q  <= '1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MAX_VALID:      max_valid_q <= cfg_data_i;
        CFG_MIN_VALID:      min_valid_q <= cfg_data_i;
        CFG_MAX_DIFFERENCE: max_diff_q  <= cfg_data_i[DIFF_W-1:0];
        default: ; // drop writes beyond the register list
      endcase
    end
  end

  state_e                   state_q;
  logic        [ADDR_W-1:0] slot_q;     // next ring write slot
  logic                     full_q;     // ring has wrapped
  logic signed [DATA_W-1:0] held_q;     // stored median
  logic signed [DATA_W-1:0] samp_q;     // sample under work
  logic                     rng_ok_q;   // sample inside [min, max]
  logic        [ADDR_W-1:0] i_q;        // pivot slot
  logic        [ADDR_W-1:0] j_q;        // compared slot
  // Read tags: what the data returning next cycle is.
  logic                     rk_piv_q;
  logic                     rk_cmp_q;
  logic                     rk_last_q;
  logic signed [DATA_W-1:0] piv_q;
  logic signed [BAL_W-1:0]  bal_q;
  logic        [BAL_W-1:0]  best_q;     // smallest balance magnitude so far
  logic signed [DATA_W-1:0] best_val_q;
  logic        [ZC_W-1:0]   zc_q;       // zero entries seen
  // Output register.
  logic                     ovld_q;
  logic                     ores_q;
  logic signed [DATA_W-1:0] omed_q;
  logic                     ofill_q;

  ring_req_t                ring_req;
  logic signed [DATA_W-1:0] rdata;
  logic                     in_acc;
  logic                     in_range;
  logic signed [BAL_W-1:0]  bal_d;
  logic        [BAL_W-1:0]  mag;
  logic signed [DATA_W:0]   diff;
  logic        [DATA_W:0]   adiff;
  logic                     close;
  logic                     oslot_free;
  logic                     oload;

  mgoc_ring u_ring (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (ring_req),
    .rdata_o (rdata)
  );

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign in_range   = !((sample_i > max_valid_q) || (sample_i < min_valid_q));
  assign oslot_free = !ovld_q || out_ready_i;
  assign oload      = (state_q == S_CHK) && oslot_free;

  // Ring access: write on acceptance, read pivot or compared slot.
  always_comb begin
    ring_req.we    = in_acc;
    ring_req.waddr = slot_q;
    ring_req.wdata = sample_i;
    ring_req.raddr = (state_q == S_PIV) ? i_q : j_q;
  end

  // Rank balance: +1 when pivot is larger, -1 when smaller. Self compare adds 0.
  always_comb begin
    bal_d = bal_q;
    if (piv_q > rdata) begin
      bal_d = bal_q + BAL_W'(1);
    end else if (piv_q < rdata) begin
      bal_d = bal_q - BAL_W'(1);
    end
    mag = (bal_d < 0) ? BAL_W'(-bal_d) : BAL_W'(bal_d);
  end

  // Distance check against the held median.
  assign diff  = {samp_q[DATA_W-1], samp_q} - {held_q[DATA_W-1], held_q};
  assign adiff = diff[DATA_W] ? (DATA_W+1)'(-diff) : diff;
  assign close = (adiff <= {{(DATA_W+1-DIFF_W){1'b0}}, max_diff_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      slot_q     <= '0;
      full_q     <= 1'b0;
      held_q     <= '0;
      samp_q     <= '0;
      rng_ok_q   <= 1'b0;
      i_q        <= '0;
      j_q        <= '0;
      rk_piv_q   <= 1'b0;
      rk_cmp_q   <= 1'b0;
      rk_last_q  <= 1'b0;
      piv_q      <= '0;
      bal_q      <= '0;
      best_q     <= '0;
      best_val_q <= '0;
      zc_q       <= '0;
      ovld_q     <= 1'b0;
      ores_q     <= 1'b0;
      omed_q     <= '0;
      ofill_q    <= 1'b0;
    end else begin
      // Load a new result, or retire the waiting one.
      if (oload) begin
        ovld_q <= 1'b1;
      end else if (ovld_q && out_ready_i) begin
        ovld_q <= 1'b0;
      end

      // Tag the read issued this cycle.
      rk_piv_q  <= (state_q == S_PIV);
      rk_cmp_q  <= (state_q == S_CMP);
      rk_last_q <= (state_q == S_CMP) && (j_q == ADDR_W'(DEPTH - 1));

      // Consume returning read data by its tag.
      if (rk_piv_q) begin
        piv_q <= rdata;
        bal_q <= '0;
        if (rdata == '0) begin
          zc_q <= zc_q + ZC_W'(1);
        end
      end
      if (rk_cmp_q) begin
        bal_q <= bal_d;
        if (rk_last_q && (piv_q != '0) && (mag < best_q)) begin
          best_q     <= mag;
          best_val_q <= piv_q;
        end
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            samp_q   <= sample_i;
            rng_ok_q <= in_range;
            if (slot_q == ADDR_W'(DEPTH - 1)) begin
              slot_q <= '0;
              full_q <= 1'b1;
            end else begin
              slot_q <= slot_q + ADDR_W'(1);
            end
            i_q    <= '0;
            j_q    <= '0;
            zc_q   <= '0;
            best_q <= BAL_W'(DEPTH);
            state_q <= in_range ? S_PIV : S_CHK;
          end
        end
        S_PIV: begin
          j_q      <= '0;
          state_q  <= S_CMP;
        end
        S_CMP: begin
          if (j_q == ADDR_W'(DEPTH - 1)) begin
            if (i_q == ADDR_W'(DEPTH - 1)) begin
              state_q <= S_DRAIN;
            end else begin
              i_q     <= i_q + ADDR_W'(1);
              state_q <= S_PIV;
            end
          end else begin
            j_q <= j_q + ADDR_W'(1);
          end
        end
        S_DRAIN: begin
          // last compare is consumed this cycle
          state_q <= S_FIN;
        end
        S_FIN: begin
          held_q  <= (zc_q >= ZC_W'(DEPTH / 2)) ? '0 : best_val_q;
          state_q <= S_CHK;
        end
        S_CHK: begin
          // Load the result once the output register is free.
          if (oslot_free) begin
            ores_q  <= rng_ok_q && close;
            omed_q  <= held_q;
            ofill_q <= full_q;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = ovld_q;
  assign valid_res_o = ores_q;
  assign median_o    = omed_q;
  assign filled_o    = ofill_q;

endmodule
`default_nettype wire

// ===== rtl/mgoc_ring.sv =====
// Sample ring: synchronous memory with registered read and per-entry valid bits.
`default_nettype none
module mgoc_ring import mgoc_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire ring_req_t         req_i,
  output logic      [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  vld_q;
  logic [DATA_W-1:0] rd_q;
  logic              rd_vld_q;

  // Write port and registered read data.
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rd_q <= mem[req_i.raddr];
  end

  // Entries never written read as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (req_i.we) begin
        vld_q[req_i.waddr] <= 1'b1;
      end
      rd_vld_q <= vld_q[req_i.raddr];
    end
  end

  assign rdata_o = rd_vld_q ? rd_q : '0;

endmodule
`default_nettype wire
